@@ hdl/apool_pkg.sv @@
`timescale 1ns / 1ps

package apool_pkg;

    // Field and storage widths.
    localparam int SAMPLE_W = 32;
    localparam int ACC_W    = 40;
    localparam int CH_W     = 10;
    localparam int POS_W    = 12;
    localparam int TAP_W    = 8;
    localparam int CC_W     = 11;
    localparam int IW_W     = 13;
    localparam int WN_W     = 9;
    localparam int RC_W     = 17;
    localparam int PROD_W   = ACC_W + RC_W + 1;
    localparam int FRAC_W   = 16;

    // Accumulator store depth.
    localparam int MAX_CHANNELS = 1024;

    // Register limits.
    localparam logic [CC_W-1:0] CC_MAX = 11'd1024;
    localparam logic [IW_W-1:0] IW_MAX = 13'd4096;
    localparam logic [WN_W-1:0] WN_MAX = 9'd256;
    localparam logic [RC_W-1:0] RC_MAX = 17'd65536;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_IN_WIDTH      = 2'd1;
    localparam logic [1:0] CFG_WINDOW        = 2'd2;
    localparam logic [1:0] CFG_WINDOW_RECIP  = 2'd3;

    // Clamped configuration seen by the datapath.
    typedef struct packed {
        logic [CC_W-1:0] cc;
        logic [IW_W-1:0] iw;
        logic [WN_W-1:0] wn;
        logic [RC_W-1:0] rc;
        logic [IW_W-1:0] out_width;
        logic            busy;
    } cfg_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]            ch;
        logic                       tap_zero;
        logic                       emit;
        logic [POS_W-1:0]           out_pos;
        logic                       last;
    } item_t;

endpackage

@@ hdl/apool_ram.sv @@
`timescale 1ns / 1ps

module apool_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Registered read; a read of the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/apool_cfg.sv @@
`timescale 1ns / 1ps

module apool_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [1:0]           wr_index,
    input  logic [16:0]          wr_data,
    output apool_pkg::cfg_t      cfg
);

    import apool_pkg::*;

    localparam int CNT_W = $clog2(IW_W + 1);

    logic [CC_W-1:0] cc_raw_reg;
    logic [IW_W-1:0] iw_raw_reg;
    logic [WN_W-1:0] wn_raw_reg;
    logic [RC_W-1:0] rc_raw_reg;

    logic [CC_W-1:0] cc;
    logic [IW_W-1:0] iw;
    logic [WN_W-1:0] wn;
    logic [RC_W-1:0] rc;

    logic             start_reg;
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WN_W-1:0]  rem_reg;
    logic [IW_W-1:0]  quo_reg;
    logic [IW_W-1:0]  out_width_reg;

    logic [WN_W:0]    shifted;
    logic             take;
    logic [WN_W-1:0]  rem_next;
    logic [IW_W-1:0]  quo_next;

    // Zero acts as one for the three count registers; values above the limit act as the limit.
    always_comb
    begin
        cc = (cc_raw_reg == '0) ? CC_W'(1) : ((cc_raw_reg > CC_MAX) ? CC_MAX : cc_raw_reg);
        iw = (iw_raw_reg == '0) ? IW_W'(1) : ((iw_raw_reg > IW_MAX) ? IW_MAX : iw_raw_reg);
        wn = (wn_raw_reg == '0) ? WN_W'(1) : ((wn_raw_reg > WN_MAX) ? WN_MAX : wn_raw_reg);
        rc = (rc_raw_reg > RC_MAX) ? RC_MAX : rc_raw_reg;
    end

    // One restoring step of in_width / window per cycle.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[IW_W-1]};
        take     = (shifted >= {1'b0, wn});
        rem_next = take ? WN_W'(shifted - {1'b0, wn}) : shifted[WN_W-1:0];
        quo_next = {quo_reg[IW_W-2:0], take};
    end

    // Register writes and the output-width divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_raw_reg    <= CC_W'(1);
            iw_raw_reg    <= IW_W'(1);
            wn_raw_reg    <= WN_W'(1);
            rc_raw_reg    <= RC_MAX;
            start_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_width_reg <= IW_W'(1);
        end
        else
        begin
            start_reg <= 1'b0;
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_CHANNEL_COUNT: cc_raw_reg <= wr_data[CC_W-1:0];
                    CFG_IN_WIDTH:
                    begin
                        iw_raw_reg <= wr_data[IW_W-1:0];
                        start_reg  <= 1'b1;
                    end
                    CFG_WINDOW:
                    begin
                        wn_raw_reg <= wr_data[WN_W-1:0];
                        start_reg  <= 1'b1;
                    end
                    CFG_WINDOW_RECIP:  rc_raw_reg <= wr_data[RC_W-1:0];
                    default: ;
                endcase
            end

            if (start_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(IW_W);
                rem_reg  <= '0;
                quo_reg  <= iw;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg      <= 1'b0;
                    out_width_reg <= quo_next;
                end
            end
        end
    end

    always_comb
    begin
        cfg.cc        = cc;
        cfg.iw        = iw;
        cfg.wn        = wn;
        cfg.rc        = rc;
        cfg.out_width = out_width_reg;
        cfg.busy      = busy_reg || start_reg;
    end

endmodule

@@ hdl/apool_front.sv @@
`timescale 1ns / 1ps

module apool_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  apool_pkg::cfg_t              cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [31:0]           in_sample,
    input  logic                         q_full,
    output logic                         q_push,
    output apool_pkg::item_t             q_item
);

    import apool_pkg::*;

    logic [CH_W-1:0]  ch_reg;
    logic [TAP_W-1:0] tap_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] oidx_reg;

    logic accept;
    logic last_ch;
    logic last_pos;
    logic last_tap;
    logic in_range;

    assign in_ready = !cfg.busy && !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the current item from the position counters.
    always_comb
    begin
        last_ch  = ({1'b0, ch_reg} + CC_W'(1)) >= cfg.cc;
        last_pos = ({1'b0, pos_reg} + IW_W'(1)) >= cfg.iw;
        last_tap = ({1'b0, tap_reg} + WN_W'(1)) >= cfg.wn;
        in_range = {1'b0, oidx_reg} < cfg.out_width;

        q_item.sample   = in_sample;
        q_item.ch       = ch_reg;
        q_item.tap_zero = (tap_reg == '0);
        q_item.emit     = last_tap;
        q_item.out_pos  = oidx_reg;
        q_item.last     = (({1'b0, oidx_reg} + IW_W'(1)) == cfg.out_width) && last_ch;
        q_push          = accept && in_range;
    end

    // Channel, tap, position and output counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg   <= '0;
            tap_reg  <= '0;
            pos_reg  <= '0;
            oidx_reg <= '0;
        end
        else if (accept)
        begin
            if (last_ch)
            begin
                ch_reg <= '0;
                if (last_pos)
                begin
                    pos_reg  <= '0;
                    tap_reg  <= '0;
                    oidx_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                    if (last_tap)
                    begin
                        tap_reg  <= '0;
                        oidx_reg <= oidx_reg + POS_W'(1);
                    end
                    else
                    begin
                        tap_reg <= tap_reg + TAP_W'(1);
                    end
                end
            end
            else
            begin
                ch_reg <= ch_reg + CH_W'(1);
            end
        end
    end

endmodule

@@ hdl/apool_fifo.sv @@
`timescale 1ns / 1ps

module apool_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  apool_pkg::item_t     push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output apool_pkg::item_t     head
);

    import apool_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    // Two-entry queue between the front and the back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                entry_reg[wr_ptr_reg] <= push_item;
                wr_ptr_reg            <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hdl/apool_back.sv @@
`timescale 1ns / 1ps

module apool_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  apool_pkg::cfg_t      cfg,
    input  logic                 q_empty,
    input  apool_pkg::item_t     q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   out_avg,
    output logic [9:0]           out_channel,
    output logic [11:0]          out_pos,
    output logic                 out_last
);

    import apool_pkg::*;

    localparam int Q_W = PROD_W - FRAC_W;

    logic                     en;
    logic [ACC_W-1:0]         rd_data;

    item_t                    s1_item_reg;
    logic                     s1_valid_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  sample_ext;

    logic                     s2_valid_reg;
    logic                     s2_emit_reg;
    logic [CH_W-1:0]          s2_ch_reg;
    logic [POS_W-1:0]         s2_pos_reg;
    logic                     s2_last_reg;
    logic signed [ACC_W-1:0]  s2_acc_reg;

    logic                     s3_valid_reg;
    logic [CH_W-1:0]          s3_ch_reg;
    logic [POS_W-1:0]         s3_pos_reg;
    logic                     s3_last_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic signed [Q_W-1:0]    q_val;
    logic signed [31:0]       avg_next;

    logic                     out_valid_reg;
    logic signed [31:0]       out_avg_reg;
    logic [CH_W-1:0]          out_ch_reg;
    logic [POS_W-1:0]         out_pos_reg;
    logic                     out_last_reg;

    // The whole back pipeline moves whenever the output register can take a word.
    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    apool_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_CHANNELS)
    ) u_sums (
        .clk   (clk),
        .we    (en && s1_valid_reg),
        .waddr (s1_item_reg.ch),
        .wdata (acc_next),
        .re    (q_pop),
        .raddr (q_head.ch),
        .rdata (rd_data)
    );

    // Accumulate; the word written on the same edge as the read is forwarded.
    always_comb
    begin
        sample_ext = ACC_W'($signed(s1_item_reg.sample));
        base       = (s2_valid_reg && (s2_ch_reg == s1_item_reg.ch)) ? s2_acc_reg
                                                                      : $signed(rd_data);
        acc_next   = s1_item_reg.tap_zero ? sample_ext : base + sample_ext;
        prod_next  = s2_acc_reg * $signed({1'b0, cfg.rc});
    end

    // Drop the fraction with floor and clamp to 32 bits.
    always_comb
    begin
        q_val = s3_prod_reg[PROD_W-1:FRAC_W];
        if (q_val[Q_W-1:31] == '0 || q_val[Q_W-1:31] == '1)
        begin
            avg_next = q_val[31:0];
        end
        else if (q_val[Q_W-1])
        begin
            avg_next = 32'sh8000_0000;
        end
        else
        begin
            avg_next = 32'sh7FFF_FFFF;
        end
    end

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_emit_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= q_head;

            s2_emit_reg <= s1_item_reg.emit;
            s2_ch_reg   <= s1_item_reg.ch;
            s2_pos_reg  <= s1_item_reg.out_pos;
            s2_last_reg <= s1_item_reg.last;
            s2_acc_reg  <= acc_next;

            s3_ch_reg   <= s2_ch_reg;
            s3_pos_reg  <= s2_pos_reg;
            s3_last_reg <= s2_last_reg;
            s3_prod_reg <= prod_next;

            out_avg_reg  <= avg_next;
            out_ch_reg   <= s3_ch_reg;
            out_pos_reg  <= s3_pos_reg;
            out_last_reg <= s3_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_avg     = out_avg_reg;
    assign out_channel = out_ch_reg;
    assign out_pos     = out_pos_reg;
    assign out_last    = out_last_reg;

endmodule

@@ hdl/average_pool_1d_stream_top.sv @@
`timescale 1ns / 1ps

// Channel  Handshake                 Payload
// in       in_valid / in_ready       sample
// out      out_valid / out_ready     avg_value, channel, out_position, last_of_image
// cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle is accepted while in_ready is high, and one result per cycle can
// leave while out_ready is high; the accumulator store is read and written in the same
// cycle, with a one-word forward for repeats. A result passes through the queue, the
// s1, s2 and s3 stages and the output register. After a write of in_width or window,
// in_ready stays low while the output width is divided out one bit per cycle. Reset
// leaves the store unwritten. A stalled output freezes the back pipeline; the two-entry
// queue then fills and in_ready drops. cfg_ready is always high.

module average_pool_1d_stream_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] avg_value,
    output logic [9:0]         channel,
    output logic [11:0]        out_position,
    output logic               last_of_image,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    import apool_pkg::*;

    cfg_t  cfg;
    item_t push_item;
    item_t head;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    assign cfg_ready = 1'b1;

    apool_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    apool_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_sample (sample),
        .q_full    (full),
        .q_push    (push),
        .q_item    (push_item)
    );

    apool_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    apool_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (empty),
        .q_head      (head),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_avg     (avg_value),
        .out_channel (channel),
        .out_pos     (out_position),
        .out_last    (last_of_image)
    );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import apool_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int RANDOM_ITEMS  = 170;

    // One expected average as it should leave the block.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg;
        logic [CH_W-1:0]            ch;
        logic [POS_W-1:0]           pos;
        logic                       last;
    } pool_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] avg_value;
    logic [CH_W-1:0]            channel;
    logic [POS_W-1:0]           out_position;
    logic                       last_of_image;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index = CFG_CHANNEL_COUNT;
    logic [RC_W-1:0]            cfg_data = '0;

    // Shadow copy of the registers and the pooling state.
    logic [CC_W-1:0]         cfg_channels = 11'd1;
    logic [IW_W-1:0]         cfg_width = 13'd1;
    logic [WN_W-1:0]         cfg_window = 9'd1;
    logic [RC_W-1:0]         cfg_recip = RC_MAX;
    logic signed [ACC_W-1:0] window_sums [MAX_CHANNELS];
    int unsigned             next_channel = 0;
    int unsigned             next_tap = 0;
    int unsigned             next_in_pos = 0;
    int unsigned             next_out_pos = 0;

    pool_result_t expected_avgs [$];
    int           mismatches = 0;
    int           cycle_count = 0;
    int           free_items = 0;
    int           ready_left = 0;

    average_pool_1d_stream_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .avg_value     (avg_value),
        .channel       (channel),
        .out_position  (out_position),
        .last_of_image (last_of_image),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // A register of zero acts as one, anything above the limit as the limit.
    function automatic int unsigned clamp_reg(int unsigned value, int unsigned limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    // Reciprocal of the window in Q1.16, rounded the way software writes it.
    function automatic int unsigned recip_for(int unsigned win);
        int unsigned w;
        w = clamp_reg(win, WN_MAX);
        return (65536 + w / 2) / w;
    endfunction

    // Mostly random words, with the extremes and small values mixed in.
    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom();
        endcase
    endfunction

    // Sender idle time: runs without gaps, short gaps, and now and then a long one.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(99);
        if (free_items > 0) begin
            free_items--;
            return 0;
        end
        if (roll < 5) begin
            free_items = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Accumulate one accepted sample and queue the average it completes, if any.
    task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] value);
        int unsigned             channels;
        int unsigned             width;
        int unsigned             win;
        int unsigned             recip;
        int unsigned             out_width;
        int unsigned             ch;
        logic signed [ACC_W-1:0] sum;
        longint                  product;
        longint                  average;
        pool_result_t            res;
        channels  = clamp_reg(cfg_channels, CC_MAX);
        width     = clamp_reg(cfg_width, IW_MAX);
        win       = clamp_reg(cfg_window, WN_MAX);
        recip     = (cfg_recip > RC_MAX) ? RC_MAX : cfg_recip;
        out_width = width / win;
        ch        = next_channel % MAX_CHANNELS;

        if (next_out_pos < out_width) begin
            if (next_tap == 0)
                sum = ACC_W'(value);
            else
                sum = window_sums[ch] + ACC_W'(value);
            window_sums[ch] = sum;

            // Last tap of the window: scale, floor and clamp to 32 bits.
            if (next_tap + 1 >= win) begin
                product = longint'(sum) * longint'(recip);
                average = product >>> FRAC_W;
                if (average > 64'sd2147483647)
                    average = 64'sd2147483647;
                else if (average < -64'sd2147483648)
                    average = -64'sd2147483648;
                res.avg  = 32'(average);
                res.ch   = ch[CH_W-1:0];
                res.pos  = next_out_pos[POS_W-1:0];
                res.last = (next_out_pos + 1 == out_width) && (next_channel + 1 >= channels);
                expected_avgs.push_back(res);
            end
        end

        // Step the channel, tap, position and output counters.
        if (next_channel + 1 >= channels) begin
            next_channel = 0;
            if (next_in_pos + 1 >= width) begin
                next_in_pos  = 0;
                next_tap     = 0;
                next_out_pos = 0;
            end else begin
                next_in_pos++;
                if (next_tap + 1 >= win) begin
                    next_tap = 0;
                    next_out_pos++;
                end else begin
                    next_tap++;
                end
            end
        end else begin
            next_channel++;
        end
    endtask

    // Offer one sample, wait for it to be taken, then maybe idle.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_sample(value);
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and let every expected average come out, then let the pipe empty.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_avgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller lowers the valid after the last write.
    task automatic write_register(input logic [1:0] index, input logic [RC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            CFG_CHANNEL_COUNT: cfg_channels = value[CC_W-1:0];
            CFG_IN_WIDTH:      cfg_width = value[IW_W-1:0];
            CFG_WINDOW:        cfg_window = value[WN_W-1:0];
            CFG_WINDOW_RECIP:  cfg_recip = value[RC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_pool_config(input int unsigned channels, input int unsigned width,
                                   input int unsigned win, input int unsigned recip);
        wait_for_idle();
        write_register(CFG_CHANNEL_COUNT, RC_W'(channels));
        write_register(CFG_IN_WIDTH, RC_W'(width));
        write_register(CFG_WINDOW, RC_W'(win));
        write_register(CFG_WINDOW_RECIP, RC_W'(recip));
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Compare each delivered average with the oldest one expected.
    always @(posedge clk) begin : check_results
        pool_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_avgs.size() == 0) begin
                report_mismatch($sformatf("unexpected average %0d ch %0d pos %0d",
                                          avg_value, channel, out_position));
            end else begin
                want = expected_avgs.pop_front();
                if (avg_value !== want.avg)
                    report_mismatch($sformatf("avg_value %0d, want %0d", avg_value, want.avg));
                if (channel !== want.ch)
                    report_mismatch($sformatf("channel %0d, want %0d", channel, want.ch));
                if (out_position !== want.pos)
                    report_mismatch($sformatf("out_position %0d, want %0d",
                                              out_position, want.pos));
                if (last_of_image !== want.last)
                    report_mismatch($sformatf("last_of_image %0b, want %0b",
                                              last_of_image, want.last));
            end
        end
    end

    // Receiver: stretches of readiness alternate with stalls, mostly short.
    always @(posedge clk) begin
        if (ready_left == 0) begin
            if ($urandom_range(99) < 60) begin
                out_ready  <= 1'b1;
                ready_left = $urandom_range(1, 40);
            end else begin
                out_ready  <= 1'b0;
                ready_left = ($urandom_range(9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 3);
            end
        end else begin
            ready_left--;
        end
    end

    // Hang guard.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Reset values pass every sample straight through.
    task automatic test_reset_defaults();
        send_sample(32'sh0000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(-32'sd1);
        send_sample(32'sh0001_0000);
        send_sample(32'sh5555_AAAA);
    endtask

    // Two channels, windows of two, and a trailing position with no output.
    task automatic test_window_with_tail();
        int i;
        set_pool_config(2, 5, 2, recip_for(2));
        for (i = 0; i < 10; i++)
            send_sample(draw_sample());
    endtask

    // Reciprocal written above its limit, so sums clamp at both bounds.
    task automatic test_saturation();
        set_pool_config(1, 2, 2, 131071);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh8000_0000);
    endtask

    task automatic test_zero_recip();
        set_pool_config(1, 2, 2, 0);
        send_sample(-32'sd12345);
        send_sample(32'sh8000_0000);
    endtask

    // Window longer than the image: samples are consumed, nothing comes out.
    task automatic test_no_full_window();
        set_pool_config(1, 3, 5, recip_for(5));
        send_sample(draw_sample());
        send_sample(draw_sample());
        send_sample(draw_sample());
    endtask

    // Zero in the count registers behaves as one.
    task automatic test_zero_registers();
        set_pool_config(0, 0, 0, 65536);
        send_sample(draw_sample());
        send_sample(draw_sample());
    endtask

    // Shrink the image width at a window boundary, past the current position.
    task automatic test_midimage_change();
        set_pool_config(1, 12, 2, recip_for(2));
        send_sample(draw_sample());
        send_sample(draw_sample());
        set_pool_config(1, 2, 2, recip_for(2));
        send_sample(draw_sample());
    endtask

    // Largest channel count, window and width, each written above its limit.
    task automatic test_extreme_configs();
        int i;
        // Channel count acts as 1024: the first channels of one position, then
        // one sample under a single channel brings the counters back to zero.
        set_pool_config(2047, 1, 1, 65536);
        for (i = 0; i < 40; i++)
            send_sample(draw_sample());
        set_pool_config(1, 1, 1, 65536);
        send_sample(draw_sample());
        // Image width acts as 4096: the first positions, then the same wrap.
        set_pool_config(1, 8191, 1, 65536);
        for (i = 0; i < 40; i++)
            send_sample(draw_sample());
        set_pool_config(1, 1, 1, 65536);
        send_sample(draw_sample());
        // Window acts as 256: one full window fills the whole image.
        set_pool_config(1, 256, 511, recip_for(256));
        for (i = 0; i < 256; i++)
            send_sample(draw_sample());
    endtask

    // Whole images under random settings, with an occasional full drain mid-stream.
    task automatic test_random_streams();
        int sent;
        int phase;
        int channels;
        int width;
        int win;
        int recip;
        int per_image;
        int items;
        int pause_at;
        int i;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            channels = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            width    = $urandom_range(1, 24);
            win      = ($urandom_range(9) < 8) ? $urandom_range(1, (width < 8) ? width : 8)
                                               : $urandom_range(1, 16);
            recip    = ($urandom_range(4) == 0) ? $urandom_range(0, 131071) : recip_for(win);
            set_pool_config(channels, width, win, recip);
            per_image = channels * width;
            items     = per_image * (1 + $urandom_range(0, 60 / per_image));
            pause_at  = (phase == 0 || $urandom_range(4) == 0) ? $urandom_range(1, items) : -1;
            for (i = 0; i < items; i++) begin
                if (i == pause_at)
                    wait_for_idle();
                send_sample(draw_sample());
            end
            sent += items;
            phase++;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_window_with_tail();
        test_saturation();
        test_zero_recip();
        test_no_full_window();
        test_zero_registers();
        test_midimage_change();
        test_extreme_configs();
        test_random_streams();

        wait_for_idle();
        if (mismatches == 0 && expected_avgs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
